### sv/pscomp_pkg.sv
// Shared types and constants for the pressure sensor compensation core.
`default_nettype none
package pscomp_pkg;

  localparam int TEMP_PIVOT     = 2000;
  localparam int TEMP_MIN_CENTI = -4000;
  localparam int TEMP_MAX_CENTI = 8500;
  localparam int PRES_MAX_DECI  = 200000;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS_BASE         = 3'd0,
    REG_OFFSET_BASE       = 3'd1,
    REG_SENS_TEMP_COEFF   = 3'd2,
    REG_OFFSET_TEMP_COEFF = 3'd3,
    REG_REF_TEMPERATURE   = 3'd4,
    REG_TEMP_SLOPE        = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } in_word_t;

  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [17:0]        pressure_decimbar;
  } out_word_t;

  typedef struct packed {
    logic [15:0] sens_base;
    logic [15:0] offset_base;
    logic [15:0] sens_temp_coeff;
    logic [15:0] offset_temp_coeff;
    logic [15:0] ref_temperature;
    logic [15:0] temp_slope;
  } cal_t;

  // First-order results handed from the front half to the back half
  typedef struct packed {
    logic               valid;
    logic               low_branch;
    logic [23:0]        raw_pressure;
    logic signed [14:0] temperature_centi;
    logic signed [35:0] off;
    logic signed [34:0] sens;
    logic signed [35:0] dsq;
  } mid_t;

endpackage
`default_nettype wire

### sv/pscomp_regs.sv
// Calibration register file written through the configuration channel.
`default_nettype none
module pscomp_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [pscomp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                    cfg_data,
  output pscomp_pkg::cal_t                    cal
);
  import pscomp_pkg::*;

  cal_t cal_r;
  cal_t cal_nxt;

  assign cfg_ready = 1'b1;
  assign cal       = cal_r;

  always_comb begin
    cal_nxt = cal_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_SENS_BASE:         cal_nxt.sens_base         = cfg_data;
        REG_OFFSET_BASE:       cal_nxt.offset_base       = cfg_data;
        REG_SENS_TEMP_COEFF:   cal_nxt.sens_temp_coeff   = cfg_data;
        REG_OFFSET_TEMP_COEFF: cal_nxt.offset_temp_coeff = cfg_data;
        REG_REF_TEMPERATURE:   cal_nxt.ref_temperature   = cfg_data;
        REG_TEMP_SLOPE:        cal_nxt.temp_slope        = cfg_data;
        default:               cal_nxt = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/pscomp_front.sv
// Stages 1-3: temperature difference, calibration products, first-order terms.
`default_nettype none
module pscomp_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire pscomp_pkg::in_word_t in_data,
  input  wire pscomp_pkg::cal_t  cal,
  output pscomp_pkg::mid_t       mid
);
  import pscomp_pkg::*;

  // stage 1
  logic               v1_r;
  logic [23:0]        d1_s1_r;
  logic signed [24:0] dt_r;
  logic signed [24:0] dt_nxt;
  // stage 2
  logic               v2_r;
  logic [23:0]        d1_s2_r;
  logic signed [41:0] dtc6_r;
  logic signed [41:0] offm_r;
  logic signed [41:0] sensm_r;
  logic signed [49:0] dtsq_r;
  // stage 3
  logic               v3_r;
  logic               low_r;
  logic [23:0]        d1_s3_r;
  logic signed [14:0] tout_r;
  logic signed [35:0] off_r;
  logic signed [34:0] sens_r;
  logic signed [35:0] dsq_r;

  // stage 3 combinational terms
  logic signed [17:0] d;
  logic signed [18:0] temp;
  logic [48:0]        dtsq_u;
  logic [50:0]        dtsq_x3;
  logic [51:0]        dtsq_x7;
  logic [17:0]        t2;
  logic signed [19:0] tout;
  logic signed [14:0] tout_sat;
  logic signed [35:0] off_nxt;
  logic signed [34:0] sens_nxt;

  assign dt_nxt = $signed({1'b0, in_data.raw_temperature})
                - $signed({1'b0, cal.ref_temperature, 8'h00});

  always_comb begin
    d       = $signed(dtc6_r[40:23]);
    temp    = 19'(TEMP_PIVOT) + {d[17], d};
    dtsq_u  = dtsq_r[48:0];
    dtsq_x3 = {2'b00, dtsq_u} + {1'b0, dtsq_u, 1'b0};
    dtsq_x7 = {dtsq_u, 3'b000} - {3'b000, dtsq_u};
    // temp below pivot is exactly a negative d
    if (d[17]) begin
      t2 = dtsq_x3[50:33];
    end else begin
      t2 = {3'b000, dtsq_x7[51:37]};
    end
    tout = {temp[18], temp} - $signed({2'b00, t2});
    if (tout < TEMP_MIN_CENTI) begin
      tout_sat = 15'(TEMP_MIN_CENTI);
    end else if (tout > TEMP_MAX_CENTI) begin
      tout_sat = 15'(TEMP_MAX_CENTI);
    end else begin
      tout_sat = tout[14:0];
    end
    off_nxt  = $signed({4'b0000, cal.offset_base, 16'h0000})
             + {offm_r[41], offm_r[41:7]};
    sens_nxt = $signed({4'b0000, cal.sens_base, 15'h0000})
             + {sensm_r[41], sensm_r[41:8]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    d1_s1_r <= in_data.raw_pressure;
    dt_r    <= dt_nxt;

    d1_s2_r <= d1_s1_r;
    dtc6_r  <= dt_r * $signed({1'b0, cal.temp_slope});
    offm_r  <= dt_r * $signed({1'b0, cal.offset_temp_coeff});
    sensm_r <= dt_r * $signed({1'b0, cal.sens_temp_coeff});
    dtsq_r  <= dt_r * dt_r;

    d1_s3_r <= d1_s2_r;
    low_r   <= d[17];
    tout_r  <= tout_sat;
    off_r   <= off_nxt;
    sens_r  <= sens_nxt;
    dsq_r   <= d * d;
  end

  always_comb begin
    mid.valid             = v3_r;
    mid.low_branch        = low_r;
    mid.raw_pressure      = d1_s3_r;
    mid.temperature_centi = tout_r;
    mid.off               = off_r;
    mid.sens              = sens_r;
    mid.dsq               = dsq_r;
  end

endmodule
`default_nettype wire

### sv/pscomp_back.sv
// Stages 4-7: second-order correction, split pressure product, saturation.
`default_nettype none
module pscomp_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pscomp_pkg::mid_t  mid,
  output logic                   out_valid,
  output pscomp_pkg::out_word_t  out_data
);
  import pscomp_pkg::*;

  // stage 4
  logic               v4_r;
  logic [23:0]        d1_s4_r;
  logic signed [14:0] t_s4_r;
  logic signed [37:0] offc_r;
  logic signed [35:0] sensc_r;
  // stage 5
  logic               v5_r;
  logic signed [14:0] t_s5_r;
  logic signed [37:0] off_s5_r;
  logic [41:0]        plo_r;
  logic signed [42:0] phi_r;
  // stage 6
  logic               v6_r;
  logic signed [14:0] t_s6_r;
  logic signed [37:0] off_s6_r;
  logic signed [40:0] pa_r;
  // output
  logic               out_valid_r;
  out_word_t          out_data_r;

  logic [34:0]        q2;
  logic [36:0]        q2_x3;
  logic [36:0]        q2_x5;
  logic [35:0]        off2;
  logic [33:0]        sens2;
  logic signed [37:0] offc_nxt;
  logic signed [35:0] sensc_nxt;
  logic signed [61:0] full;
  logic signed [41:0] pb;
  logic signed [26:0] p;
  logic [17:0]        p_sat;

  always_comb begin
    q2    = mid.dsq[34:0];
    q2_x3 = {2'b00, q2} + {1'b0, q2, 1'b0};
    q2_x5 = {2'b00, q2} + {q2, 2'b00};
    if (mid.low_branch) begin
      off2  = q2_x3[36:1];
      sens2 = q2_x5[36:3];
    end else begin
      off2  = {5'b00000, q2[34:4]};
      sens2 = '0;
    end
    offc_nxt  = {{2{mid.off[35]}}, mid.off} - $signed({2'b00, off2});
    sensc_nxt = {mid.sens[34], mid.sens} - $signed({2'b00, sens2});
  end

  always_comb begin
    // recombine the two partial products of D1 * SENS
    full = $signed({phi_r[42], phi_r, 18'h00000}) + $signed({20'h00000, plo_r});
    pb   = {pa_r[40], pa_r} - {{4{off_s6_r[37]}}, off_s6_r};
    p    = pb[41:15];
    if (p < 0) begin
      p_sat = '0;
    end else if (p > PRES_MAX_DECI) begin
      p_sat = 18'(PRES_MAX_DECI);
    end else begin
      p_sat = p[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v4_r        <= mid.valid;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      out_valid_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    d1_s4_r  <= mid.raw_pressure;
    t_s4_r   <= mid.temperature_centi;
    offc_r   <= offc_nxt;
    sensc_r  <= sensc_nxt;

    t_s5_r   <= t_s4_r;
    off_s5_r <= offc_r;
    plo_r    <= d1_s4_r * sensc_r[17:0];
    phi_r    <= $signed({1'b0, d1_s4_r}) * $signed(sensc_r[35:18]);

    t_s6_r   <= t_s5_r;
    off_s6_r <= off_s5_r;
    pa_r     <= full[61:21];

    out_data_r.temperature_centi <= t_s6_r;
    out_data_r.pressure_decimbar <= p_sat;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

### sv/pressure_sensor_compensation_core.sv
// Throughput: one word per cycle while busy is low.
// The seven-stage multiplier chain is fully pipelined.
// busy is high only during reset; the receiver cannot stall, so no backpressure exists.
// Reset: synchronous active-low rst_n clears the pipeline valid bits and sets the
// six calibration registers to zero.
`default_nettype none
module pressure_sensor_compensation_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire pscomp_pkg::in_word_t             in_data,
  output logic                                  out_valid,
  output pscomp_pkg::out_word_t                 out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [pscomp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                      cfg_data
);
  import pscomp_pkg::*;

  logic busy_r;
  logic in_accept;
  cal_t cal;
  mid_t mid;

  // hold off input while in reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy      = busy_r;
  assign in_accept = start && !busy_r;

  pscomp_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cal       (cal)
  );

  pscomp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_accept),
    .in_data  (in_data),
    .cal      (cal),
    .mid      (mid)
  );

  pscomp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid       (mid),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> ##7 out_valid)
    else $error("accepted word did not produce a result after 7 cycles");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    !mid.valid |-> ##4 !out_valid)
    else $error("result strobe without a matching word in the pipeline");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.temperature_centi >= 15'(TEMP_MIN_CENTI)) &&
                  (out_data.temperature_centi <= 15'(TEMP_MAX_CENTI)))
    else $error("temperature result outside saturation range");

  a_pres_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pressure_decimbar <= 18'(PRES_MAX_DECI)))
    else $error("pressure result outside saturation range");
`endif

endmodule
`default_nettype wire

### sim/pressure_sensor_compensation_core_tb.sv
// Self-checking testbench for the pressure sensor compensation core.
module pressure_sensor_compensation_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pscomp_pkg::*;

  localparam int LATENCY         = 7;
  localparam int PHASES          = 12;
  localparam int WORDS_PER_PHASE = 100;
  localparam int CYCLE_LIMIT     = 200000;

  // Indexes outside the register map; writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

  localparam logic [23:0] RAW_MAX = 24'hFFFFFF;
  localparam logic [15:0] CAL_MAX = 16'hFFFF;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [15:0]          data;
    in_word_t             word;
    logic                 has_exp;
    out_word_t            exp;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_word_t             in_data = '0;
  logic                 out_valid;
  out_word_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;

  cal_t        cal_shadow = '0;
  out_word_t   pending_results[$];
  plan_row_t   plan_q[$];
  int          errors = 0;
  int          cycles = 0;
  int          burst_left = 0;

  pressure_sensor_compensation_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Second-order compensation of one reading pair with the shadow calibration
  function automatic out_word_t compensate(in_word_t w);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, temp, off, sens, d, t2, off2, sens2, p, tout;
    out_word_t r;
    d1 = longint'(w.raw_pressure);
    d2 = longint'(w.raw_temperature);
    c1 = longint'(cal_shadow.sens_base);
    c2 = longint'(cal_shadow.offset_base);
    c3 = longint'(cal_shadow.sens_temp_coeff);
    c4 = longint'(cal_shadow.offset_temp_coeff);
    c5 = longint'(cal_shadow.ref_temperature);
    c6 = longint'(cal_shadow.temp_slope);
    dt   = d2 - c5 * 256;
    temp = TEMP_PIVOT + ((dt * c6) >>> 23);
    off  = c2 * 65536 + ((c4 * dt) >>> 7);
    sens = c1 * 32768 + ((c3 * dt) >>> 8);
    d    = temp - TEMP_PIVOT;
    if (temp < TEMP_PIVOT) begin
      t2    = (3 * dt * dt) >>> 33;
      off2  = (3 * d * d) >>> 1;
      sens2 = (5 * d * d) >>> 3;
    end else begin
      t2    = (7 * dt * dt) >>> 37;
      off2  = (d * d) >>> 4;
      sens2 = 0;
    end
    tout = temp - t2;
    off  = off - off2;
    sens = sens - sens2;
    p    = (((d1 * sens) >>> 21) - off) >>> 15;
    if (tout < TEMP_MIN_CENTI) tout = TEMP_MIN_CENTI;
    if (tout > TEMP_MAX_CENTI) tout = TEMP_MAX_CENTI;
    if (p < 0) p = 0;
    if (p > PRES_MAX_DECI) p = PRES_MAX_DECI;
    r.temperature_centi = tout[14:0];
    r.pressure_decimbar = p[17:0];
    return r;
  endfunction

  function automatic void plan_cfg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    plan_q.push_back(r);
  endfunction

  function automatic void plan_word(logic [23:0] p, logic [23:0] t);
    plan_row_t r;
    r = '0;
    r.word.raw_pressure = p;
    r.word.raw_temperature = t;
    plan_q.push_back(r);
  endfunction

  function automatic void plan_word_exp(logic [23:0] p, logic [23:0] t, int et, int ep);
    plan_row_t r;
    r = '0;
    r.word.raw_pressure = p;
    r.word.raw_temperature = t;
    r.has_exp = 1'b1;
    r.exp.temperature_centi = 15'(et);
    r.exp.pressure_decimbar = 18'(ep);
    plan_q.push_back(r);
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int pick, span, offs;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      // realistic pair: temperature reading around the reference point
      case ($urandom_range(0, 2))
        0:       span = 1 << 10;
        1:       span = 1 << 16;
        default: span = 1 << 21;
      endcase
      offs = int'($urandom_range(0, 2 * span)) - span;
      w.raw_temperature = 24'(int'(cal_shadow.ref_temperature) * 256 + offs);
      w.raw_pressure = 24'($urandom_range(1000000, 12000000));
    end else if (pick < 85) begin
      w.raw_pressure = 24'($urandom);
      w.raw_temperature = 24'($urandom);
    end else begin
      case ($urandom_range(0, 3))
        0:       w.raw_pressure = '0;
        1:       w.raw_pressure = RAW_MAX;
        2:       w.raw_pressure = 24'h800000;
        default: w.raw_pressure = 24'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       w.raw_temperature = '0;
        1:       w.raw_temperature = RAW_MAX;
        2:       w.raw_temperature = 24'h800000;
        default: w.raw_temperature = 24'($urandom);
      endcase
    end
    return w;
  endfunction

  function automatic logic [15:0] jitter(int base);
    return 16'(base + int'($urandom_range(0, 4000)) - 2000);
  endfunction

  function automatic logic [15:0] rail();
    return ($urandom_range(0, 1) != 0) ? CAL_MAX : 16'h0000;
  endfunction

  function automatic cal_t phase_cal(int phase);
    cal_t c;
    int pick;
    pick = $urandom_range(0, 99);
    if (phase == 0) begin
      c = '1;
    end else if (phase == 1) begin
      c = '0;
    end else if (phase == 2 || pick < 50) begin
      c.sens_base         = (phase == 2) ? 16'd46372 : jitter(46372);
      c.offset_base       = (phase == 2) ? 16'd43981 : jitter(43981);
      c.sens_temp_coeff   = (phase == 2) ? 16'd29059 : jitter(29059);
      c.offset_temp_coeff = (phase == 2) ? 16'd27842 : jitter(27842);
      c.ref_temperature   = (phase == 2) ? 16'd31553 : jitter(31553);
      c.temp_slope        = (phase == 2) ? 16'd28165 : jitter(28165);
    end else if (pick < 85) begin
      c = {$urandom, $urandom, $urandom};
    end else begin
      c = {rail(), rail(), rail(), rail(), rail(), rail()};
    end
    return c;
  endfunction

  // Hold the write until the register port takes it; caller drops cfg_valid
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_SENS_BASE:         cal_shadow.sens_base = value;
      REG_OFFSET_BASE:       cal_shadow.offset_base = value;
      REG_SENS_TEMP_COEFF:   cal_shadow.sens_temp_coeff = value;
      REG_OFFSET_TEMP_COEFF: cal_shadow.offset_temp_coeff = value;
      REG_REF_TEMPERATURE:   cal_shadow.ref_temperature = value;
      REG_TEMP_SLOPE:        cal_shadow.temp_slope = value;
      default: ;
    endcase
  endtask

  task automatic load_cal(cal_t c);
    cfg_write(REG_SENS_BASE, c.sens_base);
    cfg_write(REG_OFFSET_BASE, c.offset_base);
    cfg_write(REG_SENS_TEMP_COEFF, c.sens_temp_coeff);
    cfg_write(REG_OFFSET_TEMP_COEFF, c.offset_temp_coeff);
    cfg_write(REG_REF_TEMPERATURE, c.ref_temperature);
    cfg_write(REG_TEMP_SLOPE, c.temp_slope);
    if ($urandom_range(0, 2) == 0)
      cfg_write(($urandom_range(0, 1) != 0) ? REG_UNUSED_6 : REG_UNUSED_7, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Present one word, hold start until accepted, then maybe open a gap
  task automatic send_word(in_word_t w, out_word_t typed, logic use_typed);
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(use_typed ? typed : compensate(w));
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected word temp=%0d pres=%0d", $time,
                 out_data.temperature_centi, out_data.pressure_decimbar);
      end else begin
        want = pending_results.pop_front();
        if (out_data.temperature_centi !== want.temperature_centi) begin
          errors++;
          $display("%0t: temperature_centi expected %0d actual %0d", $time,
                   want.temperature_centi, out_data.temperature_centi);
        end
        if (out_data.pressure_decimbar !== want.pressure_decimbar) begin
          errors++;
          $display("%0t: pressure_decimbar expected %0d actual %0d", $time,
                   want.pressure_decimbar, out_data.pressure_decimbar);
        end
      end
    end else if (rst_n && out_valid !== 1'b0) begin
      errors++;
      $display("%0t: out_valid expected 0 or 1 actual %b", $time, out_valid);
    end
  end

  initial begin
    // calibration all zero after reset
    plan_word_exp(24'd0, 24'd0, 2000, 0);
    plan_word_exp(RAW_MAX, RAW_MAX, TEMP_MIN_CENTI, 0);
    plan_word(24'd0, 24'h800000);
    // writes outside the map must leave calibration untouched
    plan_cfg(REG_UNUSED_6, CAL_MAX);
    plan_cfg(REG_UNUSED_7, 16'h1234);
    plan_word_exp(RAW_MAX, 24'd0, 2000, 0);
    plan_cfg(REG_SENS_BASE, CAL_MAX);
    plan_word_exp(RAW_MAX, 24'd0, 2000, PRES_MAX_DECI);
    // large offset drives pressure negative
    plan_cfg(REG_SENS_BASE, 16'd0);
    plan_cfg(REG_OFFSET_BASE, CAL_MAX);
    plan_word_exp(RAW_MAX, 24'd0, 2000, 0);
    // negative sensitivity at the pivot temperature
    plan_cfg(REG_OFFSET_BASE, 16'd0);
    plan_cfg(REG_SENS_TEMP_COEFF, CAL_MAX);
    plan_cfg(REG_OFFSET_TEMP_COEFF, 16'd0);
    plan_cfg(REG_REF_TEMPERATURE, CAL_MAX);
    plan_cfg(REG_TEMP_SLOPE, 16'd0);
    plan_word_exp(RAW_MAX, 24'd0, TEMP_MIN_CENTI, 0);
    plan_word(24'h800000, RAW_MAX);
    // every register at its maximum
    plan_cfg(REG_SENS_BASE, CAL_MAX);
    plan_cfg(REG_OFFSET_BASE, CAL_MAX);
    plan_cfg(REG_OFFSET_TEMP_COEFF, CAL_MAX);
    plan_cfg(REG_TEMP_SLOPE, CAL_MAX);
    plan_word(RAW_MAX, RAW_MAX);
    plan_word(24'd0, 24'd0);
    plan_word(RAW_MAX, 24'h800000);
    // typical factory calibration
    plan_cfg(REG_SENS_BASE, 16'd46372);
    plan_cfg(REG_OFFSET_BASE, 16'd43981);
    plan_cfg(REG_SENS_TEMP_COEFF, 16'd29059);
    plan_cfg(REG_OFFSET_TEMP_COEFF, 16'd27842);
    plan_cfg(REG_REF_TEMPERATURE, 16'd31553);
    plan_cfg(REG_TEMP_SLOPE, 16'd28165);
    plan_word(24'd4311550, 24'd8387300);
    plan_word(24'd4311550, 24'd8077636);
    plan_word(24'd4311550, 24'd8077568);  // exactly at the pivot
    plan_word(24'd4311550, 24'd8077567);  // one step below the pivot
    plan_word(24'd4311550, 24'd6977568);  // below -15 C, no extra term
    plan_word(24'd4311550, 24'd0);
    plan_word(24'd4311550, RAW_MAX);
    plan_word(24'd0, 24'd8387300);
    plan_word(RAW_MAX, 24'd8387300);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < plan_q.size(); i++) begin
      if (plan_q[i].is_cfg) begin
        if (i == 0 || !plan_q[i-1].is_cfg) drain_results();
        cfg_write(plan_q[i].idx, plan_q[i].data);
        if (i + 1 == plan_q.size() || !plan_q[i+1].is_cfg) cfg_valid <= 1'b0;
      end else begin
        send_word(plan_q[i].word, plan_q[i].exp, plan_q[i].has_exp);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      load_cal(phase_cal(ph));
      for (int n = 0; n < WORDS_PER_PHASE; n++)
        send_word(random_word(), '0, 1'b0);
    end

    drain_results();
    repeat (LATENCY + 5) @(posedge clk);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
